[sv/mctc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mctc_pkg
// Shared types and constants of the multi-console text cursor engine.
// ----------------------------------------------------------------------------
package mctc_pkg;

    localparam int VMEM_CELLS_DEF   = 16384;
    localparam int NUM_CONSOLES_DEF = 4;
    localparam int SCREEN_COLS_DEF  = 80;
    localparam int SCREEN_CELLS_DEF = 2000;

    localparam int CELL_W = 14;
    localparam int IDX_W  = 3;
    localparam int BYTE_W = 8;

    localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [BYTE_W-1:0] ATTR_RESET   = 8'h07;

    typedef logic [CELL_W-1:0] cell_t;
    typedef logic [BYTE_W-1:0] byte_t;

    typedef enum logic [1:0] {
        CMD_PUT         = 2'd0,
        CMD_SCROLL_UP   = 2'd1,
        CMD_SCROLL_DOWN = 2'd2,
        CMD_SWITCH      = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t              command;
        logic [IDX_W-1:0]  console;
        byte_t             char_code;
    } req_t;

    typedef struct packed {
        logic  state_we;
        logic  shown_we;
    } ctl_t;

    typedef struct packed {
        logic  write_enable;
        cell_t write_cell;
        byte_t write_char;
        byte_t write_attr;
        cell_t crt_cursor;
        cell_t crt_start;
        logic  addressed_is_shown;
    } out_t;

endpackage
`default_nettype wire

[sv/mctc_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mctc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mctc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

[sv/mctc_update.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mctc_update
// Per-request cursor and view update of one console entry.
// ----------------------------------------------------------------------------
module mctc_update #(
    parameter int VMEM_CELLS   = mctc_pkg::VMEM_CELLS_DEF,
    parameter int NUM_CONSOLES = mctc_pkg::NUM_CONSOLES_DEF,
    parameter int SCREEN_COLS  = mctc_pkg::SCREEN_COLS_DEF,
    parameter int SCREEN_CELLS = mctc_pkg::SCREEN_CELLS_DEF,
    parameter int IW  = (NUM_CONSOLES > 1) ? $clog2(NUM_CONSOLES) : 1,
    parameter int OW  = $clog2(VMEM_CELLS + SCREEN_CELLS + 1),
    parameter int CLW = $clog2(SCREEN_COLS)
) (
    input  wire mctc_pkg::req_t req,
    input  wire logic [IW-1:0]  entry_addr,
    input  wire logic [IW-1:0]  shown,
    input  wire logic [OW-1:0]  row_base,
    input  wire logic [CLW-1:0] col,
    input  wire logic [OW-1:0]  view_off,
    input  wire mctc_pkg::byte_t attr,
    output logic [OW-1:0]       upd_row,
    output logic [CLW-1:0]      upd_col,
    output logic [OW-1:0]       upd_view,
    output mctc_pkg::ctl_t  ctl,
    output mctc_pkg::out_t  res
);

    localparam int REGION = VMEM_CELLS / NUM_CONSOLES;
    localparam logic [OW-1:0]  REGION_W = OW'(REGION);
    localparam logic [OW-1:0]  COLS_W   = OW'(SCREEN_COLS);
    localparam logic [OW-1:0]  SCELLS_W = OW'(SCREEN_CELLS);
    localparam logic [CLW-1:0] COL_LAST = CLW'(SCREEN_COLS - 1);

    logic          in_range;
    logic          affect;
    logic          is_bs;
    logic          cell_we;
    logic [OW-1:0] origin;
    logic [OW-1:0] cur;
    logic [OW-1:0] cur_new;

    always_comb
    begin
        in_range = ({1'b0, req.console} < (mctc_pkg::IDX_W + 1)'(NUM_CONSOLES));
        affect   = in_range && (req.command != mctc_pkg::CMD_SWITCH);
        origin   = OW'(entry_addr) * REGION_W;
        cur      = row_base + OW'(col);
        upd_row  = row_base;
        upd_col  = col;
        upd_view = view_off;
        cell_we  = 1'b0;
        is_bs    = 1'b0;
        unique case (req.command)
            mctc_pkg::CMD_PUT:
            begin
                if (req.char_code == mctc_pkg::CH_NEWLINE)
                begin
                    if (row_base + COLS_W < REGION_W)
                    begin
                        upd_row = row_base + COLS_W;
                        upd_col = '0;
                    end
                end
                else if (req.char_code == mctc_pkg::CH_BACKSPACE)
                begin
                    is_bs = 1'b1;
                    if (cur != '0)
                    begin
                        cell_we = 1'b1;
                        if (col == '0)
                        begin
                            upd_row = row_base - COLS_W;
                            upd_col = COL_LAST;
                        end
                        else
                        begin
                            upd_col = col - 1'b1;
                        end
                    end
                end
                else if (cur < REGION_W - 1'b1)
                begin
                    cell_we = 1'b1;
                    if (col == COL_LAST)
                    begin
                        upd_row = row_base + COLS_W;
                        upd_col = '0;
                    end
                    else
                    begin
                        upd_col = col + 1'b1;
                    end
                end
            end
            mctc_pkg::CMD_SCROLL_UP:
            begin
                if (view_off + SCELLS_W < REGION_W)
                begin
                    upd_view = view_off + COLS_W;
                end
            end
            mctc_pkg::CMD_SCROLL_DOWN:
            begin
                if (view_off >= COLS_W)
                begin
                    upd_view = view_off - COLS_W;
                end
                else
                begin
                    upd_view = '0;
                end
            end
            mctc_pkg::CMD_SWITCH:
            begin
                upd_view = view_off;
            end
            default:
            begin
                upd_view = view_off;
            end
        endcase
        cur_new = upd_row + OW'(upd_col);
        // re-home the view on the cursor row
        if ((req.command == mctc_pkg::CMD_PUT) &&
            ((cur_new >= view_off + SCELLS_W) || (cur_new < view_off)))
        begin
            upd_view = upd_row;
        end

        ctl.state_we = affect;
        ctl.shown_we = in_range && (req.command == mctc_pkg::CMD_SWITCH);

        res.write_enable = affect && cell_we;
        res.write_cell   = '0;
        res.write_char   = '0;
        res.write_attr   = '0;
        if (res.write_enable)
        begin
            res.write_cell = mctc_pkg::cell_t'(origin + (is_bs ? cur_new : cur));
            res.write_char = is_bs ? mctc_pkg::CH_SPACE : req.char_code;
            res.write_attr = attr;
        end
        res.crt_cursor = mctc_pkg::cell_t'(origin + (affect ? cur_new : cur));
        res.crt_start  = mctc_pkg::cell_t'(origin + (affect ? upd_view : view_off));
        res.addressed_is_shown = ctl.shown_we || (affect && (entry_addr == shown));
    end

endmodule
`default_nettype wire

[sv/multi_console_text_cursor_engine_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_console_text_cursor_engine_unit
// Text-mode engine for several virtual consoles: per-console cursor and
// view start kept in a small RAM, one request in, one result out.
//
//   channel   signals                                   handshake
//   in        command, console_index, char_code         in_valid / in_ready
//   out       write_enable .. addressed_is_shown        out_valid / out_ready
//   cfg       cfg_wr_data (text attribute)              cfg_wr_en
//
// One request per cycle sustained while results are taken; the accepting
// edge reads the console RAM, then the update goes to the result register.
// Reset leaves every console at its region origin through per-entry valid
// bits, so no clearing pass is needed. A stalled result holds the update
// stage; input is taken whenever that stage is empty or moves on.
// ----------------------------------------------------------------------------
module multi_console_text_cursor_engine_unit #(
    parameter int VMEM_CELLS   = mctc_pkg::VMEM_CELLS_DEF,
    parameter int NUM_CONSOLES = mctc_pkg::NUM_CONSOLES_DEF,
    parameter int SCREEN_COLS  = mctc_pkg::SCREEN_COLS_DEF,
    parameter int SCREEN_CELLS = mctc_pkg::SCREEN_CELLS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  command,
    input  wire logic [2:0]  console_index,
    input  wire logic [7:0]  char_code,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             write_enable,
    output logic [13:0]      write_cell,
    output logic [7:0]       write_char,
    output logic [7:0]       write_attr,
    output logic [13:0]      crt_cursor,
    output logic [13:0]      crt_start,
    output logic             addressed_is_shown
);

    localparam int IW  = (NUM_CONSOLES > 1) ? $clog2(NUM_CONSOLES) : 1;
    localparam int OW  = $clog2(VMEM_CELLS + SCREEN_CELLS + 1);
    localparam int CLW = $clog2(SCREEN_COLS);
    localparam int EW  = 2 * OW + CLW;

    mctc_pkg::byte_t   attr_reg;
    logic [IW-1:0]     shown_reg;
    logic              s1_valid_reg;
    mctc_pkg::req_t    s1_req_reg;
    logic [IW-1:0]     s1_addr_reg;
    logic [NUM_CONSOLES-1:0] valid_reg;
    logic              fwd_valid_reg;
    logic [IW-1:0]     fwd_addr_reg;
    logic [EW-1:0]     fwd_data_reg;
    logic              out_valid_reg;
    mctc_pkg::out_t    out_reg;

    mctc_pkg::req_t    in_req;
    mctc_pkg::ctl_t    ctl;
    mctc_pkg::out_t    res;
    logic              in_fire;
    logic              s1_adv;
    logic              in_range_in;
    logic [IW-1:0]     shown_now;
    logic [IW-1:0]     rd_addr;
    logic [EW-1:0]     rd_data;
    logic [EW-1:0]     entry;
    logic [EW-1:0]     wr_data;
    logic              ram_we;
    logic [OW-1:0]     upd_row;
    logic [CLW-1:0]    upd_col;
    logic [OW-1:0]     upd_view;

    assign in_req.command   = mctc_pkg::cmd_t'(command);
    assign in_req.console   = console_index;
    assign in_req.char_code = char_code;

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_fire  = in_valid && in_ready;
    assign ram_we   = s1_adv && ctl.state_we;

    assign in_range_in = ({1'b0, console_index} < (mctc_pkg::IDX_W + 1)'(NUM_CONSOLES));
    assign shown_now   = (s1_adv && ctl.shown_we) ? s1_req_reg.console[IW-1:0] : shown_reg;
    assign rd_addr     = in_range_in ? console_index[IW-1:0] : shown_now;

    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg))
        begin
            entry = fwd_data_reg;
        end
        else if (valid_reg[s1_addr_reg])
        begin
            entry = rd_data;
        end
        else
        begin
            entry = '0;
        end
    end

    assign wr_data = {upd_row, upd_col, upd_view};

    mctc_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_CONSOLES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (s1_addr_reg),
        .wr_data (wr_data),
        .rd_en   (in_fire),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    mctc_update #(
        .VMEM_CELLS   (VMEM_CELLS),
        .NUM_CONSOLES (NUM_CONSOLES),
        .SCREEN_COLS  (SCREEN_COLS),
        .SCREEN_CELLS (SCREEN_CELLS)
    ) u_update (
        .req        (s1_req_reg),
        .entry_addr (s1_addr_reg),
        .shown      (shown_reg),
        .row_base   (entry[EW-1 -: OW]),
        .col        (entry[OW +: CLW]),
        .view_off   (entry[OW-1:0]),
        .attr       (attr_reg),
        .upd_row    (upd_row),
        .upd_col    (upd_col),
        .upd_view   (upd_view),
        .ctl        (ctl),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg      <= mctc_pkg::ATTR_RESET;
            shown_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            valid_reg     <= '0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                attr_reg <= cfg_wr_data;
            end
            if (s1_adv && ctl.shown_we)
            begin
                shown_reg <= s1_req_reg.console[IW-1:0];
            end
            if (ram_we)
            begin
                valid_reg[s1_addr_reg] <= 1'b1;
            end
            // capture the write that lands with this read
            if (in_fire)
            begin
                fwd_valid_reg <= ram_we;
            end
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_req_reg   <= in_req;
            s1_addr_reg  <= rd_addr;
            fwd_addr_reg <= s1_addr_reg;
            fwd_data_reg <= wr_data;
        end
        if (s1_adv)
        begin
            out_reg <= res;
        end
    end

    assign out_valid          = out_valid_reg;
    assign write_enable       = out_reg.write_enable;
    assign write_cell         = out_reg.write_cell;
    assign write_char         = out_reg.write_char;
    assign write_attr         = out_reg.write_attr;
    assign crt_cursor         = out_reg.crt_cursor;
    assign crt_start          = out_reg.crt_start;
    assign addressed_is_shown = out_reg.addressed_is_shown;

`ifndef SYNTHESIS
    a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !write_enable |->
            write_cell == '0 && write_char == '0 && write_attr == '0)
        else $error("cell fields set without a cell write");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(s1_addr_reg))
        else $error("update stage lost its request while stalled");

    a_shown_range: assert property (@(posedge clk) disable iff (!rst_n)
        shown_reg < NUM_CONSOLES)
        else $error("shown console out of range");

    a_write_slot: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> s1_valid_reg && !(out_valid_reg && !out_ready))
        else $error("console RAM written without a result slot");
`endif

endmodule
`default_nettype wire

[dv/console_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// console_result_checker
// Watches the request, result and attribute ports of the text cursor
// engine, keeps its own copy of every console's cursor and view start,
// predicts the result of each accepted request and compares it field by
// field with what the block returns. Counts failures for the testbench top.
// ----------------------------------------------------------------------------
module console_result_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  command,
    input  logic [2:0]  console_index,
    input  logic [7:0]  char_code,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        write_enable,
    input  logic [13:0] write_cell,
    input  logic [7:0]  write_char,
    input  logic [7:0]  write_attr,
    input  logic [13:0] crt_cursor,
    input  logic [13:0] crt_start,
    input  logic        addressed_is_shown,
    output int          errors_seen,
    output int          results_checked,
    output int          results_pending
);

    localparam int unsigned CONSOLES = mctc_pkg::NUM_CONSOLES_DEF;
    localparam int unsigned REGION   =
        mctc_pkg::VMEM_CELLS_DEF / mctc_pkg::NUM_CONSOLES_DEF;
    localparam int unsigned COLS     = mctc_pkg::SCREEN_COLS_DEF;
    localparam int unsigned SCREEN   = mctc_pkg::SCREEN_CELLS_DEF;

    int unsigned     cursor_pos [CONSOLES];
    int unsigned     view_pos   [CONSOLES];
    int unsigned     shown_sel;
    mctc_pkg::byte_t attr_now;

    mctc_pkg::out_t screen_updates_due [$];

    function automatic mctc_pkg::out_t step_console_model(mctc_pkg::cmd_t cmd,
                                                          logic [2:0] idx,
                                                          mctc_pkg::byte_t ch);
        mctc_pkg::out_t r;
        int unsigned    o;
        int unsigned    lim;
        int unsigned    c;
        int unsigned    v;
        int unsigned    nc;
        r = '0;
        if (idx >= CONSOLES)
        begin
            r.crt_cursor = mctc_pkg::cell_t'(cursor_pos[shown_sel]);
            r.crt_start  = mctc_pkg::cell_t'(view_pos[shown_sel]);
        end
        else if (cmd == mctc_pkg::CMD_SWITCH)
        begin
            shown_sel = idx;
            r.crt_cursor = mctc_pkg::cell_t'(cursor_pos[idx]);
            r.crt_start  = mctc_pkg::cell_t'(view_pos[idx]);
            r.addressed_is_shown = 1'b1;
        end
        else
        begin
            o   = idx * REGION;
            lim = o + REGION;
            c   = cursor_pos[idx];
            v   = view_pos[idx];
            if (cmd == mctc_pkg::CMD_PUT)
            begin
                if (ch == mctc_pkg::CH_NEWLINE)
                begin
                    nc = o + COLS * ((c - o) / COLS + 1);
                    if (nc < lim)
                        c = nc;
                end
                else if (ch == mctc_pkg::CH_BACKSPACE)
                begin
                    if (c > o)
                    begin
                        c = c - 1;
                        r.write_enable = 1'b1;
                        r.write_cell   = mctc_pkg::cell_t'(c);
                        r.write_char   = mctc_pkg::CH_SPACE;
                        r.write_attr   = attr_now;
                    end
                end
                else if (c < lim - 1)
                begin
                    r.write_enable = 1'b1;
                    r.write_cell   = mctc_pkg::cell_t'(c);
                    r.write_char   = ch;
                    r.write_attr   = attr_now;
                    c = c + 1;
                end
                if (c >= v + SCREEN || c < v)
                    v = o + COLS * ((c - o) / COLS);
            end
            else if (cmd == mctc_pkg::CMD_SCROLL_UP)
            begin
                if (v + SCREEN < lim)
                    v = v + COLS;
            end
            else if (v > o)
            begin
                if (v - o >= COLS)
                    v = v - COLS;
                else
                    v = o;
            end
            cursor_pos[idx] = c;
            view_pos[idx]   = v;
            r.crt_cursor = mctc_pkg::cell_t'(c);
            r.crt_start  = mctc_pkg::cell_t'(v);
            r.addressed_is_shown = (idx == shown_sel);
        end
        return r;
    endfunction

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            errors_seen++;
        end
    endtask

    initial
    begin
        errors_seen     = 0;
        results_checked = 0;
        results_pending = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        mctc_pkg::out_t due;
        if (!rst_n)
        begin
            for (int i = 0; i < CONSOLES; i++)
            begin
                cursor_pos[i] = i * REGION;
                view_pos[i]   = i * REGION;
            end
            shown_sel = 0;
            attr_now  = mctc_pkg::ATTR_RESET;
            screen_updates_due.delete();
            results_pending = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (screen_updates_due.size() == 0)
                begin
                    $error("unexpected result: cursor %0d start %0d", crt_cursor, crt_start);
                    errors_seen++;
                end
                else
                begin
                    due = screen_updates_due.pop_front();
                    check_field("write_enable", due.write_enable, write_enable);
                    check_field("write_cell", due.write_cell, write_cell);
                    check_field("write_char", due.write_char, write_char);
                    check_field("write_attr", due.write_attr, write_attr);
                    check_field("crt_cursor", due.crt_cursor, crt_cursor);
                    check_field("crt_start", due.crt_start, crt_start);
                    check_field("addressed_is_shown", due.addressed_is_shown,
                                addressed_is_shown);
                end
                results_checked++;
            end
            if (in_valid && in_ready)
                screen_updates_due.push_back(
                    step_console_model(mctc_pkg::cmd_t'(command), console_index,
                                       char_code));
            if (cfg_wr_en)
                attr_now = cfg_wr_data;
            results_pending = screen_updates_due.size();
        end
    end

endmodule

[dv/tb_multi_console_text_cursor_engine_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_console_text_cursor_engine_unit
// Drives requests into the text cursor engine: a directed opening on region
// edges, console switches and out-of-range consoles, then bursts of text,
// newlines, backspaces and scrolls under several idle and stall patterns,
// with one long result hold-off. A checker module predicts and compares.
// ----------------------------------------------------------------------------
module tb_multi_console_text_cursor_engine_unit;

    localparam int unsigned CONSOLES = mctc_pkg::NUM_CONSOLES_DEF;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [7:0]  cfg_wr_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  command;
    logic [2:0]  console_index;
    logic [7:0]  char_code;
    logic        out_valid;
    logic        out_ready;
    logic        write_enable;
    logic [13:0] write_cell;
    logic [7:0]  write_char;
    logic [7:0]  write_attr;
    logic [13:0] crt_cursor;
    logic [13:0] crt_start;
    logic        addressed_is_shown;

    int errors_seen;
    int results_checked;
    int results_pending;

    int send_idle_pct;
    int recv_stall_pct;
    int requests_sent;
    int attr_writes;
    bit out_hold;
    event begin_hold;

    multi_console_text_cursor_engine_unit u_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .command            (command),
        .console_index      (console_index),
        .char_code          (char_code),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .write_enable       (write_enable),
        .write_cell         (write_cell),
        .write_char         (write_char),
        .write_attr         (write_attr),
        .crt_cursor         (crt_cursor),
        .crt_start          (crt_start),
        .addressed_is_shown (addressed_is_shown)
    );

    console_result_checker u_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .command            (command),
        .console_index      (console_index),
        .char_code          (char_code),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .write_enable       (write_enable),
        .write_cell         (write_cell),
        .write_char         (write_char),
        .write_attr         (write_attr),
        .crt_cursor         (crt_cursor),
        .crt_start          (crt_start),
        .addressed_is_shown (addressed_is_shown),
        .errors_seen        (errors_seen),
        .results_checked    (results_checked),
        .results_pending    (results_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(negedge clk)
    begin
        if (out_hold)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // hold results back for a long stretch so the pipeline backs up
    initial
    begin
        out_hold = 1'b0;
        forever
        begin
            @(begin_hold);
            @(posedge clk);
            out_hold = 1'b1;
            repeat (300) @(posedge clk);
            out_hold = 1'b0;
        end
    end

    task automatic send_request(input mctc_pkg::cmd_t cmd, input logic [2:0] idx,
                                input mctc_pkg::byte_t ch);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        command       <= cmd;
        console_index <= idx;
        char_code     <= ch;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        requests_sent++;
    endtask

    task automatic settle_and_write_attr(input mctc_pkg::byte_t attr);
        in_valid <= 1'b0;
        while (results_pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= attr;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        attr_writes++;
    endtask

    task automatic run_random_traffic(input int count);
        int              done;
        int              kind;
        int              len;
        logic [2:0]      idx;
        mctc_pkg::cmd_t  cmd;
        mctc_pkg::byte_t ch;
        done = 0;
        while (done < count)
        begin
            kind = $urandom_range(0, 99);
            idx  = 3'($urandom_range(0, CONSOLES - 1));
            len  = $urandom_range(1, 20);
            if (kind >= 83 && kind < 93)
            begin
                idx = 3'($urandom_range(0, 7));
                len = 1;
            end
            for (int j = 0; j < len; j++)
            begin
                ch  = mctc_pkg::byte_t'($urandom_range(0, 255));
                cmd = mctc_pkg::CMD_PUT;
                if (kind < 30)
                begin
                    if ($urandom_range(0, 9) != 0)
                        ch = mctc_pkg::CH_NEWLINE;
                end
                else if (kind < 55)
                begin
                    if ($urandom_range(0, 1) == 0)
                        ch = mctc_pkg::byte_t'($urandom_range(8'h20, 8'h7E));
                end
                else if (kind < 65)
                    ch = mctc_pkg::CH_BACKSPACE;
                else if (kind < 75)
                    cmd = mctc_pkg::CMD_SCROLL_UP;
                else if (kind < 83)
                    cmd = mctc_pkg::CMD_SCROLL_DOWN;
                else if (kind < 93)
                    cmd = mctc_pkg::CMD_SWITCH;
                else
                begin
                    cmd = mctc_pkg::cmd_t'($urandom_range(0, 3));
                    idx = 3'($urandom_range(0, 7));
                end
                send_request(cmd, idx, ch);
                if (idx < CONSOLES)
                    done++;
            end
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = 8'h00;
        in_valid       = 1'b0;
        command        = mctc_pkg::CMD_PUT;
        console_index  = 3'd0;
        char_code      = 8'h00;
        out_ready      = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        requests_sent  = 0;
        attr_writes    = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_request(mctc_pkg::CMD_PUT, 3'd0, mctc_pkg::CH_BACKSPACE);
        send_request(mctc_pkg::CMD_SCROLL_DOWN, 3'd0, 8'h00);
        send_request(mctc_pkg::CMD_PUT, 3'd0, 8'h41);
        send_request(mctc_pkg::CMD_PUT, 3'd1, 8'hFF);
        send_request(mctc_pkg::CMD_PUT, 3'd3, 8'h00);
        send_request(mctc_pkg::CMD_PUT, 3'd0, mctc_pkg::CH_BACKSPACE);
        send_request(mctc_pkg::CMD_PUT, 3'd2, mctc_pkg::CH_NEWLINE);
        send_request(mctc_pkg::CMD_SCROLL_UP, 3'd2, 8'h00);
        send_request(mctc_pkg::CMD_SCROLL_DOWN, 3'd2, 8'hFF);
        send_request(mctc_pkg::CMD_SWITCH, 3'd3, 8'h00);
        send_request(mctc_pkg::CMD_PUT, 3'd3, mctc_pkg::CH_NEWLINE);
        send_request(mctc_pkg::CMD_PUT, 3'd3, 8'h7F);
        send_request(mctc_pkg::CMD_SWITCH, 3'd7, 8'h00);
        send_request(mctc_pkg::CMD_PUT, 3'd5, 8'h78);
        send_request(mctc_pkg::CMD_SCROLL_UP, 3'd4, 8'h00);
        send_request(mctc_pkg::CMD_SCROLL_DOWN, 3'd6, 8'h00);
        send_request(mctc_pkg::CMD_SWITCH, 3'd0, 8'h00);
        send_request(mctc_pkg::CMD_SCROLL_UP, 3'd1, 8'h00);
        send_request(mctc_pkg::CMD_SCROLL_UP, 3'd1, 8'h00);
        send_request(mctc_pkg::CMD_SCROLL_UP, 3'd1, 8'h00);
        send_request(mctc_pkg::CMD_PUT, 3'd1, 8'h80);
        send_request(mctc_pkg::CMD_PUT, 3'd1, mctc_pkg::CH_BACKSPACE);

        settle_and_write_attr(8'hFF);
        send_idle_pct  = 48;
        recv_stall_pct = 0;
        run_random_traffic(490);

        settle_and_write_attr(8'h00);
        send_idle_pct  = 0;
        recv_stall_pct = 48;
        run_random_traffic(490);

        settle_and_write_attr(mctc_pkg::byte_t'($urandom_range(1, 254)));
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        -> begin_hold;
        run_random_traffic(490);

        settle_and_write_attr(mctc_pkg::byte_t'($urandom_range(0, 255)));
        send_idle_pct  = 35;
        recv_stall_pct = 35;
        run_random_traffic(480);

        in_valid <= 1'b0;
        while (results_pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        $display("Run summary: %0d requests over five phases, %0d results compared,",
                 requests_sent, results_checked);
        $display("  %0d attribute writes, idle/stall patterns and one long result hold-off.",
                 attr_writes);
        if (errors_seen == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
